>>> rtl/psc_pkg.sv
// shared types and constants for the pareto ranking block
package psc_pkg;

	localparam int MAX_CATEGORIES_DEF = 64;
	localparam int COUNT_BITS_DEF     = 24;
	localparam int CAT_W              = 6;
	localparam int FREQ_W             = 24;
	localparam int PCT_W              = 23;
	localparam int PCT_SCALE          = 100 * 65536;

	typedef struct packed {
		logic [CAT_W-1:0]  category;
		logic [FREQ_W-1:0] frequency;
		logic              last_item;
	} in_beat_t;

	typedef struct packed {
		logic [CAT_W-1:0]  rank;
		logic [CAT_W-1:0]  category_out;
		logic [FREQ_W-1:0] count_out;
		logic [PCT_W-1:0]  cumulative_percent;
		logic              last_result;
	} out_beat_t;

	// divider handshake
	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

>>> rtl/psc_div.sv
// restoring divider, one quotient bit per cycle
module psc_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 30,
	parameter int Q_W   = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	// shift in next numerator bit
	assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses after the final quotient bit
			done <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q[Q_W-1:0];

	// checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with empty count");
endmodule

>>> rtl/pareto_sort_cumulative_percent.sv
// top level: load, in-memory insertion sort, ranked output with percentage
// Items load one per cycle into a count/category memory (registered read port)
// while a running total is kept; busy stays low while loading. After the item
// marked last, an insertion sort runs in the memory: for each element a read
// (S_RD_KEY) and key capture (S_KEY), then per comparison one read (S_RD_PREV)
// and one compare and shift write (S_CMP), then the key write (S_PUT). Each
// result then needs memory read states (S_RD_OUT, S_WAIT_RD), the start of a
// 56-bit bit-serial division at the default widths (S_DIV), and a wait for the quotient.
// busy stays high from the last item until the final result strobe; results
// are strobed for one cycle on out_valid and cannot be stalled.
module pareto_sort_cumulative_percent #(
	parameter int MAX_CATEGORIES = psc_pkg::MAX_CATEGORIES_DEF,
	parameter int COUNT_BITS     = psc_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psc_pkg::in_beat_t in_data,
	output logic              out_valid,
	output psc_pkg::out_beat_t out_data
);
	localparam int AW    = $clog2(MAX_CATEGORIES);
	localparam int FW    = $clog2(MAX_CATEGORIES + 1);
	localparam int TOT_W = COUNT_BITS + 6;
	localparam int NUM_W = TOT_W + 23 + 3;

	typedef enum logic [3:0] {
		S_LOAD, S_OUTER, S_RD_KEY, S_KEY, S_RD_PREV, S_CMP, S_PUT,
		S_RD_OUT, S_WAIT_RD, S_DIV, S_WAIT_DIV
	} state_t;

	state_t state_q;

	logic [COUNT_BITS-1:0]     cnt_mem [MAX_CATEGORIES];
	logic [psc_pkg::CAT_W-1:0] cat_mem [MAX_CATEGORIES];

	logic [FW-1:0]             fill_q;
	logic [TOT_W-1:0]          total_q;
	logic [TOT_W-1:0]          sum_q;
	logic [FW-1:0]             i_q;
	logic [AW-1:0]             j_q;
	logic [COUNT_BITS-1:0]     key_cnt_q;
	logic [psc_pkg::CAT_W-1:0] key_cat_q;
	logic [COUNT_BITS-1:0]     rd_cnt_q;
	logic [psc_pkg::CAT_W-1:0] rd_cat_q;

	logic                      we;
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;
	logic [COUNT_BITS-1:0]     wcnt;
	logic [psc_pkg::CAT_W-1:0] wcat;

	psc_pkg::div_ctl_t         div_ctl;
	logic [NUM_W-1:0]          div_num;
	logic [psc_pkg::PCT_W-1:0] div_quo;

	logic                      accept;
	logic [COUNT_BITS-1:0]     freq_in;
	logic [TOT_W-1:0]          sum_nx;

	assign accept  = start && !busy;
	assign freq_in = COUNT_BITS'(in_data.frequency);
	assign busy    = (state_q != S_LOAD);
	assign sum_nx  = sum_q + TOT_W'(rd_cnt_q);

	// memory write and read port selection
	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wcnt  = rd_cnt_q;
		wcat  = rd_cat_q;
		raddr = j_q;
		case (state_q)
			S_LOAD: begin
				we    = accept && (fill_q < FW'(MAX_CATEGORIES));
				waddr = fill_q[AW-1:0];
				wcnt  = freq_in;
				wcat  = in_data.category;
			end
			S_RD_KEY:  raddr = i_q[AW-1:0];
			S_RD_PREV: raddr = j_q - 1'b1;
			S_CMP: begin
				// shift the smaller previous entry one slot down
				we = (rd_cnt_q < key_cnt_q);
			end
			S_PUT: begin
				we   = 1'b1;
				wcnt = key_cnt_q;
				wcat = key_cat_q;
			end
			// hold the ranked entry on the read port until its beat is sent
			S_RD_OUT, S_WAIT_RD, S_DIV, S_WAIT_DIV: raddr = i_q[AW-1:0];
			default: ;
		endcase
	end

	// count and category memories
	always_ff @(posedge clk) begin
		if (we) begin
			cnt_mem[waddr] <= wcnt;
			cat_mem[waddr] <= wcat;
		end
		rd_cnt_q <= cnt_mem[raddr];
		rd_cat_q <= cat_mem[raddr];
	end

	assign div_num         = NUM_W'(sum_nx) * NUM_W'(psc_pkg::PCT_SCALE);
	assign div_ctl.start   = (state_q == S_DIV);

	psc_div #(.NUM_W(NUM_W), .DEN_W(TOT_W), .Q_W(psc_pkg::PCT_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_ctl.start),
		.num   (div_num),
		.den   (total_q),
		.done  (div_ctl.done),
		.quo   (div_quo)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			fill_q    <= '0;
			total_q   <= '0;
			sum_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= (state_q == S_WAIT_DIV) && div_ctl.done;
			case (state_q)
				S_LOAD: if (accept) begin
					logic [FW-1:0] nfill;
					nfill = fill_q;
					if (fill_q < FW'(MAX_CATEGORIES)) begin
						nfill   = fill_q + 1'b1;
						total_q <= total_q + TOT_W'(freq_in);
					end
					fill_q <= nfill;
					if (in_data.last_item) begin
						i_q     <= FW'(1);
						state_q <= S_OUTER;
					end
				end
				S_OUTER: begin
					if (i_q >= fill_q) begin
						i_q     <= '0;
						sum_q   <= '0;
						state_q <= S_RD_OUT;
					end else begin
						j_q     <= i_q[AW-1:0];
						state_q <= S_RD_KEY;
					end
				end
				S_RD_KEY: state_q <= S_KEY;
				S_KEY: begin
					key_cnt_q <= rd_cnt_q;
					key_cat_q <= rd_cat_q;
					state_q   <= S_RD_PREV;
				end
				S_RD_PREV: state_q <= S_CMP;
				S_CMP: begin
					if (rd_cnt_q < key_cnt_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= (j_q == AW'(1)) ? S_PUT : S_RD_PREV;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_OUTER;
				end
				S_RD_OUT:  state_q <= S_WAIT_RD;
				S_WAIT_RD: state_q <= S_DIV;
				S_DIV:     state_q <= S_WAIT_DIV;
				S_WAIT_DIV: if (div_ctl.done) begin
					out_data.rank               <= psc_pkg::CAT_W'(i_q);
					out_data.category_out       <= rd_cat_q;
					out_data.count_out          <= psc_pkg::FREQ_W'(rd_cnt_q);
					out_data.cumulative_percent <= (total_q == '0) ? '0 : div_quo;
					out_data.last_result        <= (i_q + 1'b1 == fill_q);
					sum_q                       <= sum_nx;
					if (i_q + 1'b1 == fill_q) begin
						fill_q  <= '0;
						total_q <= '0;
						state_q <= S_LOAD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RD_OUT;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_CATEGORIES)) else $error("fill level over capacity");
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> busy) else $error("result while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_result |-> !busy) else $error("not idle after set");
	a_load_noout: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !out_valid) else $error("stray result");
endmodule

>>> verif/tb_pareto_sort_cumulative_percent.sv
// testbench for the pareto ranking block: directed and random data sets checked against a ranking predictor
module tb_pareto_sort_cumulative_percent;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CAT = psc_pkg::MAX_CATEGORIES_DEF;
	localparam int LIMIT   = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	psc_pkg::in_beat_t in_data;
	logic out_valid;
	psc_pkg::out_beat_t out_data;

	pareto_sort_cumulative_percent uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_data(in_data), .out_valid(out_valid), .out_data(out_data)
	);

	// pending input beats and expected ranked results
	psc_pkg::in_beat_t pending_items[$];
	psc_pkg::out_beat_t ranked_expect[$];

	// predictor state
	logic [psc_pkg::FREQ_W-1:0] held_count[MAX_CAT];
	logic [psc_pkg::CAT_W-1:0]  held_cat[MAX_CAT];
	int                         held_fill;
	logic [29:0]                held_total;

	int  mismatches;
	int  cycles;
	bit  stim_done;
	bit  idle_free;

	// store one accepted beat; on the last item rank the set and queue results
	task automatic rank_beat(input psc_pkg::in_beat_t b);
		logic [psc_pkg::FREQ_W-1:0] c;
		logic [psc_pkg::CAT_W-1:0]  k;
		logic [63:0]                run_sum;
		psc_pkg::out_beat_t         r;
		int                         j;
		if (held_fill < MAX_CAT) begin
			held_count[held_fill] = b.frequency;
			held_cat[held_fill]   = b.category;
			held_fill++;
			held_total = held_total + 30'(b.frequency);
		end
		if (!b.last_item)
			return;
		// stable insertion sort, descending
		for (int i = 1; i < held_fill; i++) begin
			c = held_count[i];
			k = held_cat[i];
			j = i;
			while (j > 0 && held_count[j-1] < c) begin
				held_count[j] = held_count[j-1];
				held_cat[j]   = held_cat[j-1];
				j--;
			end
			held_count[j] = c;
			held_cat[j]   = k;
		end
		run_sum = 0;
		for (int i = 0; i < held_fill; i++) begin
			run_sum = run_sum + 64'(held_count[i]);
			r.rank = psc_pkg::CAT_W'(i);
			r.category_out = held_cat[i];
			r.count_out = held_count[i];
			r.cumulative_percent = (held_total == 0) ? '0 :
				psc_pkg::PCT_W'((run_sum * 64'(psc_pkg::PCT_SCALE)) / 64'(held_total));
			r.last_result = (i + 1 == held_fill);
			ranked_expect.push_back(r);
		end
		held_fill  = 0;
		held_total = 0;
	endtask

	// queue n items; mode picks the count pattern, close marks the final one last
	task automatic add_set(input int n, input int mode, input bit close = 1'b1);
		psc_pkg::in_beat_t b;
		for (int i = 0; i < n; i++) begin
			b.category = psc_pkg::CAT_W'(($urandom_range(0, 3) == 0) ? $urandom : i);
			case (mode)
				0: b.frequency = psc_pkg::FREQ_W'($urandom);
				1: b.frequency = '0;
				2: b.frequency = {psc_pkg::FREQ_W{1'b1}};
				3: b.frequency = psc_pkg::FREQ_W'($urandom_range(0, 3));
				default: b.frequency = ($urandom_range(0, 1) != 0) ?
					{psc_pkg::FREQ_W{1'b1}} : psc_pkg::FREQ_W'($urandom_range(0, 2));
			endcase
			b.last_item = close && (i == n - 1);
			pending_items.push_back(b);
		end
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// stimulus plan
	initial begin
		psc_pkg::in_beat_t b;
		arst_n = 0;
		held_fill = 0;
		held_total = 0;
		// directed: single item, zero total, all max, ties, mixed
		add_set(1, 0);
		add_set(3, 1);
		add_set(4, 2);
		add_set(6, 3);
		add_set(2, 4);
		// full store, then a dropped beat and a dropped last item
		add_set(MAX_CAT, 4, 1'b0);
		b.category = '0;
		b.frequency = '1;
		b.last_item = 0;
		pending_items.push_back(b);
		b.category = '1;
		b.frequency = psc_pkg::FREQ_W'(12345);
		b.last_item = 1;
		pending_items.push_back(b);
		// random small sets
		for (int s = 0; s < 10; s++)
			add_set($urandom_range(1, 8), $urandom_range(0, 4));
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			in_data <= '0;
			stim_done <= 0;
		end else if (!start || !busy) begin
			if (start)
				rank_beat(in_data);
			if (pending_items.size() != 0 && (idle_free || $urandom_range(0, 99) >= 17)) begin
				start <= 1;
				in_data <= pending_items.pop_front();
			end else begin
				start <= 0;
				if (pending_items.size() == 0)
					stim_done <= 1;
			end
		end
	end

	// long stretch without idle gaps in the middle of the run
	always @(posedge clk)
		idle_free <= (pending_items.size() > 40 && pending_items.size() < 100);

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (ranked_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", out_data);
			end else if (out_data !== ranked_expect[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", ranked_expect[0], out_data);
				void'(ranked_expect.pop_front());
			end else
				void'(ranked_expect.pop_front());
		end
	end

	// end of run and timeout
	initial begin
		mismatches = 0;
		cycles = 0;
		wait (arst_n);
		while (!(stim_done && !start && ranked_expect.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
		end else begin
			repeat (200) @(posedge clk);
			if (mismatches == 0 && ranked_expect.size() == 0)
				$display("ALL CHECKS PASSED");
			else
				$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
